>>> src/rmt_pkg.sv
// shared types and constants for the ratio to tuning-word pipeline
// no dependencies
`default_nettype none
package rmt_pkg;

  localparam int RATIO_BITS_DEF = 16;
  localparam int MANT_W = 32;
  localparam int FRAC_MAX_W = 32;
  localparam int EXP_W = 5;
  localparam int FRAC_SEMI_W = 14;
  localparam logic [6:0] TONAL_CENTER_RST = 7'd60;

  typedef struct packed {
    logic valid;
    logic zero;
    logic [MANT_W-1:0] mp;
    logic [MANT_W-1:0] mq;
    logic [FRAC_MAX_W-1:0] fp;
    logic [FRAC_MAX_W-1:0] fq;
    logic [EXP_W-1:0] ep;
    logic [EXP_W-1:0] eq;
    logic signed [15:0] cents;
    logic [6:0] tc;
  } rmt_cell_t;

endpackage
`default_nettype wire

>>> src/rmt_front.sv
// front end: ratio products and mantissa normalization
// depends on rmt_pkg
`default_nettype none
module rmt_front import rmt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [15:0] note_num,
  input  wire logic [15:0] note_den,
  input  wire logic [15:0] region_num,
  input  wire logic [15:0] region_den,
  input  wire logic [15:0] cent_offset,
  input  wire logic [6:0]  tc,
  output rmt_cell_t        cell_out
);

  logic        valid0;
  logic [31:0] p_r;
  logic [31:0] q_r;
  logic [15:0] cents0;
  logic [6:0]  tc0;
  logic [EXP_W-1:0] ep;
  logic [EXP_W-1:0] eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else begin
      valid0 <= accept;
    end
    p_r    <= 32'(note_num) * 32'(region_num);
    q_r    <= 32'(note_den) * 32'(region_den);
    cents0 <= cent_offset;
    tc0    <= tc;
  end

  always_comb begin
    ep = '0;
    eq = '0;
    for (int i = 0; i < 32; i++) begin
      if (p_r[i]) ep = EXP_W'(i);
      if (q_r[i]) eq = EXP_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= valid0;
    end
    cell_out.zero  <= (p_r == '0) || (q_r == '0);
    cell_out.mp    <= p_r << (5'd31 - ep);
    cell_out.mq    <= q_r << (5'd31 - eq);
    cell_out.fp    <= '0;
    cell_out.fq    <= '0;
    cell_out.ep    <= ep;
    cell_out.eq    <= eq;
    cell_out.cents <= $signed(cents0);
    cell_out.tc    <= tc0;
  end

endmodule
`default_nettype wire

>>> src/rmt_log_cell.sv
// one squaring step of the log2 chain, yields one fraction bit per mantissa
// depends on rmt_pkg
`default_nettype none
module rmt_log_cell import rmt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  rmt_cell_t cell_in,
  output rmt_cell_t cell_out
);

  logic [63:0] sp;
  logic [63:0] sq;
  logic [32:0] tp;
  logic [32:0] tq;

  assign sp = 64'(cell_in.mp) * 64'(cell_in.mp);
  assign sq = 64'(cell_in.mq) * 64'(cell_in.mq);
  assign tp = sp[63:31];
  assign tq = sq[63:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= cell_in.valid;
    end
    cell_out.zero  <= cell_in.zero;
    cell_out.mp    <= tp[32] ? tp[32:1] : tp[31:0];
    cell_out.mq    <= tq[32] ? tq[32:1] : tq[31:0];
    cell_out.fp    <= {cell_in.fp[FRAC_MAX_W-2:0], tp[32]};
    cell_out.fq    <= {cell_in.fq[FRAC_MAX_W-2:0], tq[32]};
    cell_out.ep    <= cell_in.ep;
    cell_out.eq    <= cell_in.eq;
    cell_out.cents <= cell_in.cents;
    cell_out.tc    <= cell_in.tc;
  end

endmodule
`default_nettype wire

>>> src/rmt_back.sv
// back end: semitone scaling, divide by 25, clamp and output register
// depends on rmt_pkg
`default_nettype none
module rmt_back import rmt_pkg::*; #(
  parameter int RATIO_BITS = RATIO_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  rmt_cell_t       cell_in,
  output logic            done,
  output logic [6:0]      note_number,
  output logic [6:0]      fraction_high,
  output logic [6:0]      fraction_low,
  output logic            out_of_range
);

  localparam int LW  = RATIO_BITS + 6;
  localparam int LW7 = LW + 7;
  localparam int SW  = LW7 + 16;
  localparam logic [31:0] TOP_N = 32'd52428800;
  localparam logic [34:0] RECIP_25 = 35'd1374389535;

  logic [LW-1:0]         l_raw;
  logic signed [LW7-1:0] l_ext;
  logic signed [SW-1:0]  sh;
  logic [31:0]           n_next;

  logic                  va;
  logic                  za;
  logic signed [LW7-1:0] lw_r;
  logic signed [15:0]    ca;
  logic [6:0]            tca;

  logic                  vb;
  logic                  zb;
  logic [31:0]           n_r;

  logic                  vc;
  logic                  bad_c;
  logic                  big_c;
  logic [60:0]           prod;
  logic [20:0]           t;

  assign l_raw = (LW'(cell_in.ep) << RATIO_BITS) - (LW'(cell_in.eq) << RATIO_BITS)
               + LW'(cell_in.fp[RATIO_BITS-1:0]) - LW'(cell_in.fq[RATIO_BITS-1:0]);
  assign l_ext = LW7'($signed(l_raw));
  assign sh = (SW'(lw_r) <<< 16) >>> RATIO_BITS;
  assign n_next = sh[31:0] + {{12{ca[15]}}, ca, 4'b0000} + 32'(tca) * 32'd409600;
  assign t = prod[55:35];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      done <= 1'b0;
    end else begin
      va <= cell_in.valid;
      vb <= va;
      vc <= vb;
      done <= vc;
    end
    za    <= cell_in.zero;
    lw_r  <= l_ext * LW7'(75);
    ca    <= cell_in.cents;
    tca   <= cell_in.tc;
    zb    <= za;
    n_r   <= n_next;
    bad_c <= zb || n_r[31];
    big_c <= !n_r[31] && (n_r >= TOP_N);
    prod  <= 61'(n_r[25:0]) * 61'(RECIP_25);
    if (bad_c) begin
      note_number   <= '0;
      fraction_high <= '0;
      fraction_low  <= '0;
      out_of_range  <= 1'b1;
    end else if (big_c) begin
      note_number   <= '1;
      fraction_high <= '1;
      fraction_low  <= '1;
      out_of_range  <= 1'b1;
    end else begin
      note_number   <= t[20:14];
      fraction_high <= t[13:7];
      fraction_low  <= t[6:0];
      out_of_range  <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> src/ratio_to_mts_tuning.sv
// ratio to tuning word: start passes through the front registers, the squaring cells and the back registers to done
// throughput one transaction per cycle, busy is always low
// the chain of RATIO_BITS squaring cells lies between the front and back ends
// rst clears the pipeline valid bits and sets tonal_center to 60
`default_nettype none
module ratio_to_mts_tuning import rmt_pkg::*; #(
  parameter int RATIO_BITS = RATIO_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] note_num,
  input  wire logic [15:0] note_den,
  input  wire logic [15:0] region_num,
  input  wire logic [15:0] region_den,
  input  wire logic [15:0] cent_offset,
  input  wire logic        cfg_wr,
  input  wire logic [6:0]  cfg_data,
  output logic             done,
  output logic [6:0]       note_number,
  output logic [6:0]       fraction_high,
  output logic [6:0]       fraction_low,
  output logic             out_of_range
);

  logic [6:0] tonal_center;
  rmt_cell_t  chain [0:RATIO_BITS];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tonal_center <= TONAL_CENTER_RST;
    end else if (cfg_wr) begin
      tonal_center <= cfg_data;
    end
  end

  rmt_front u_front (
    .clk, .rst,
    .accept(start && !busy),
    .note_num, .note_den, .region_num, .region_den, .cent_offset,
    .tc(tonal_center),
    .cell_out(chain[0])
  );

  for (genvar g = 0; g < RATIO_BITS; g++) begin : g_cell
    rmt_log_cell u_cell (
      .clk, .rst,
      .cell_in(chain[g]),
      .cell_out(chain[g+1])
    );
  end

  rmt_back #(.RATIO_BITS(RATIO_BITS)) u_back (
    .clk, .rst,
    .cell_in(chain[RATIO_BITS]),
    .done, .note_number, .fraction_high, .fraction_low, .out_of_range
  );

endmodule
`default_nettype wire

>>> src/rmt_checker.sv
// port-level checks for ratio_to_mts_tuning, bound to the top level
// depends on rmt_pkg
`default_nettype none
module rmt_checker import rmt_pkg::*; #(
  parameter int RATIO_BITS = RATIO_BITS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [6:0] note_number,
  input wire logic [6:0] fraction_high,
  input wire logic [6:0] fraction_low,
  input wire logic       out_of_range
);

  localparam int LAT = RATIO_BITS + 6;

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("missing result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##LAT !done)
    else $error("unexpected result");

  a_clamp_values: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |->
      (note_number == 7'd0 && fraction_high == 7'd0 && fraction_low == 7'd0) ||
      (note_number == 7'd127 && fraction_high == 7'd127 && fraction_low == 7'd127))
    else $error("bad clamp value");

endmodule

bind ratio_to_mts_tuning rmt_checker #(.RATIO_BITS(RATIO_BITS)) u_rmt_checker (
  .clk, .rst, .start, .busy, .done,
  .note_number, .fraction_high, .fraction_low, .out_of_range
);
`default_nettype wire
